>>> sv/mtpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_pkg
// Shared types and constants of the MTPA current reference pipeline.
// ----------------------------------------------------------------------------
package mtpa_pkg;

  localparam logic [1:0] CFG_CURRENT_MAX  = 2'd0;
  localparam logic [1:0] CFG_FLUX_LINKAGE = 2'd1;
  localparam logic [1:0] CFG_D_INDUCTANCE = 2'd2;
  localparam logic [1:0] CFG_Q_INDUCTANCE = 2'd3;

  localparam int VSQ_STEPS = 38;
  localparam int DIV_STEPS = 16;
  localparam int QSQ_STEPS = 16;

  typedef struct packed {
    logic [15:0] amag;
    logic        neg;
    logic        zero;
  } side_t;

  typedef struct packed {
    logic        dneg;
    logic [19:0] dmag;
    logic [19:0] flux;
  } motor_t;

endpackage

>>> sv/mtpa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_cmd_if / mtpa_res_if
// Valid/ready channels for the command and the current references.
// ----------------------------------------------------------------------------
interface mtpa_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] current_ref;
  modport source (output valid, current_ref, input ready);
  modport sink (input valid, current_ref, output ready);
endinterface

interface mtpa_res_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] d_current_ref;
  logic signed [16:0] q_current_ref;
  modport source (output valid, d_current_ref, q_current_ref, input ready);
  modport sink (input valid, d_current_ref, q_current_ref, output ready);
endinterface

>>> sv/mtpa_dsolve.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_dsolve
// d-axis solve: 76-bit square root, one bit per stage, then the quotient by
// 4*delta one bit per stage, clamp to the current magnitude.
// ----------------------------------------------------------------------------
module mtpa_dsolve (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  mtpa_pkg::motor_t   motor,
  input  logic               in_valid,
  input  logic [75:0]        v,
  input  mtpa_pkg::side_t    in_side,
  output logic               out_valid,
  output logic signed [16:0] id,
  output mtpa_pkg::side_t    out_side
);

  localparam int NS = mtpa_pkg::VSQ_STEPS;
  localparam int ND = mtpa_pkg::DIV_STEPS;

  logic [75:0]     sv    [0:NS];
  logic [39:0]     srem  [0:NS];
  logic [37:0]     sroot [0:NS];
  mtpa_pkg::side_t sside [0:NS];
  logic            svld  [0:NS];

  assign sv[0]    = v;
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign sside[0] = in_side;
  assign svld[0]  = in_valid;

  for (genvar k = 1; k <= NS; k++) begin : g_vsq
    logic [41:0] cur;
    logic [41:0] trial;
    logic        take;
    assign cur   = {srem[k-1], sv[k-1][75:74]};
    assign trial = {2'b00, sroot[k-1], 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        svld[k] <= 1'b0;
      end else if (en) begin
        svld[k] <= svld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sv[k]    <= {sv[k-1][73:0], 2'b00};
        srem[k]  <= take ? 40'(cur - trial) : cur[39:0];
        sroot[k] <= {sroot[k-1][36:0], take};
        sside[k] <= sside[k-1];
      end
    end
  end

  // numerator and overflow check
  logic [31:0] x;
  logic [21:0] dvs;
  logic [37:0] nmag;
  logic        nneg;
  assign x    = {motor.flux, 12'd0};
  assign dvs  = {motor.dmag, 2'b00};
  assign nneg = (sroot[NS] >= {6'd0, x});
  assign nmag = nneg ? (sroot[NS] - {6'd0, x}) : ({6'd0, x} - sroot[NS]);

  logic [21:0]     dr    [0:ND];
  logic [15:0]     dq    [0:ND];
  logic [15:0]     dlow  [0:ND];
  mtpa_pkg::side_t dside [0:ND];
  logic            dbig  [0:ND];
  logic            dsgn  [0:ND];
  logic            dvld  [0:ND];

  always_ff @(posedge clk) begin
    if (rst) begin
      dvld[0] <= 1'b0;
    end else if (en) begin
      dvld[0] <= svld[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dr[0]    <= nmag[37:16];
      dq[0]    <= '0;
      dlow[0]  <= nmag[15:0];
      dside[0] <= sside[NS];
      dbig[0]  <= (nmag >= {dvs, 16'd0});
      dsgn[0]  <= nneg ^ motor.dneg;
    end
  end

  for (genvar k = 1; k <= ND; k++) begin : g_div
    logic [22:0] cur;
    logic        take;
    assign cur  = {dr[k-1], dlow[k-1][15]};
    assign take = (cur >= {1'b0, dvs});

    always_ff @(posedge clk) begin
      if (rst) begin
        dvld[k] <= 1'b0;
      end else if (en) begin
        dvld[k] <= dvld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dr[k]    <= take ? 22'(cur - {1'b0, dvs}) : cur[21:0];
        dq[k]    <= {dq[k-1][14:0], take};
        dlow[k]  <= {dlow[k-1][14:0], 1'b0};
        dside[k] <= dside[k-1];
        dbig[k]  <= dbig[k-1];
        dsgn[k]  <= dsgn[k-1];
      end
    end
  end

  logic [15:0]        qc;
  logic signed [16:0] id_next;
  assign qc = (dbig[ND] || dq[ND] > dside[ND].amag) ? dside[ND].amag : dq[ND];
  assign id_next = dside[ND].zero ? 17'sd0 :
                   dsgn[ND] ? -$signed({1'b0, qc}) : $signed({1'b0, qc});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= dvld[ND];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      id       <= id_next;
      out_side <= dside[ND];
    end
  end

endmodule

>>> sv/mtpa_current_reference_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_current_reference_top
// MTPA d/q current reference for an interior permanent magnet machine.
// ----------------------------------------------------------------------------
// Fully pipelined: one command transaction is taken every cycle while the
// output is not stalled; the pipeline depth is set by the 38-stage square
// root of the 76-bit radicand, the 16-stage quotient and the 16-stage square
// root of the q-axis term. The whole pipeline holds while the output
// register has a result that is not taken. The user must write configuration
// only while no transaction is in flight; the block does not enforce it.
module mtpa_current_reference_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  mtpa_cmd_if.sink    cmd,
  mtpa_res_if.source  res
);

  localparam int NQ = mtpa_pkg::QSQ_STEPS;

  logic [15:0] current_max;
  logic [19:0] flux_linkage;
  logic [19:0] d_inductance;
  logic [19:0] q_inductance;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_max  <= '0;
      flux_linkage <= '0;
      d_inductance <= '0;
      q_inductance <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        mtpa_pkg::CFG_CURRENT_MAX:  current_max  <= cfg_data[15:0];
        mtpa_pkg::CFG_FLUX_LINKAGE: flux_linkage <= cfg_data;
        mtpa_pkg::CFG_D_INDUCTANCE: d_inductance <= cfg_data;
        mtpa_pkg::CFG_Q_INDUCTANCE: q_inductance <= cfg_data;
        default: ;
      endcase
    end
  end

  logic signed [20:0] delta;
  mtpa_pkg::motor_t   motor;
  assign delta      = $signed({1'b0, q_inductance}) - $signed({1'b0, d_inductance});
  assign motor.dneg = delta[20];
  assign motor.dmag = delta[20] ? 20'(-delta) : delta[19:0];
  assign motor.flux = flux_linkage;

  logic en;
  assign en        = !res.valid || res.ready;
  assign cmd.ready = en;

  // stage 1: command times full scale
  logic               v1;
  logic signed [32:0] prod1;
  logic signed [32:0] prod_next;
  assign prod_next = cmd.current_ref * $signed({1'b0, current_max});

  // stage 2: magnitude
  logic               v2;
  mtpa_pkg::side_t    side2;
  logic signed [32:0] adj;
  logic signed [17:0] icmd;
  assign adj  = prod1 + (prod1[32] ? 33'sd32767 : 33'sd0);
  assign icmd = adj[32:15];

  // stage 3: delta * |I|
  logic            v3;
  mtpa_pkg::side_t side3;
  logic [35:0]     y3;

  // stage 4: partial squares
  logic            v4;
  mtpa_pkg::side_t side4;
  logic [35:0]     hh4;
  logic [35:0]     hl4;
  logic [35:0]     ll4;
  logic [39:0]     ff4;

  // stage 5: radicand x^2 + 8 y^2
  logic            v5;
  mtpa_pkg::side_t side5;
  logic [75:0]     rad5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= cmd.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod1      <= prod_next;
      side2.amag <= icmd[17] ? 16'(-icmd) : icmd[15:0];
      side2.neg  <= icmd[17];
      side2.zero <= (icmd == 18'sd0) || (delta == 21'sd0);
      y3         <= 36'(motor.dmag * side2.amag);
      side3      <= side2;
      hh4        <= y3[35:18] * y3[35:18];
      hl4        <= y3[35:18] * y3[17:0];
      ll4        <= y3[17:0] * y3[17:0];
      ff4        <= flux_linkage * flux_linkage;
      side4      <= side3;
      rad5       <= {12'd0, ff4, 24'd0} + {1'b0, hh4, 39'd0}
                  + {18'd0, hl4, 22'd0} + {37'd0, ll4, 3'd0};
      side5      <= side4;
    end
  end

  logic               vd;
  logic signed [16:0] idd;
  mtpa_pkg::side_t    sided;

  mtpa_dsolve u_dsolve (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .motor     (motor),
    .in_valid  (v5),
    .v         (rad5),
    .in_side   (side5),
    .out_valid (vd),
    .id        (idd),
    .out_side  (sided)
  );

  // q axis: sqrt(A^2 - id^2)
  logic               vq1;
  logic [31:0]        a2q1;
  logic [31:0]        d2q1;
  logic signed [16:0] idq1;
  logic               negq1;
  logic [15:0]        idmag;
  assign idmag = idd[16] ? 16'(-idd) : idd[15:0];

  logic [31:0]        qv    [0:NQ];
  logic [17:0]        qrem  [0:NQ];
  logic [15:0]        qroot [0:NQ];
  logic signed [16:0] qid   [0:NQ];
  logic               qneg  [0:NQ];
  logic               qvld  [0:NQ];

  always_ff @(posedge clk) begin
    if (rst) begin
      vq1     <= 1'b0;
      qvld[0] <= 1'b0;
    end else if (en) begin
      vq1     <= vd;
      qvld[0] <= vq1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a2q1     <= sided.amag * sided.amag;
      d2q1     <= idmag * idmag;
      idq1     <= idd;
      negq1    <= sided.neg;
      qv[0]    <= a2q1 - d2q1;
      qrem[0]  <= '0;
      qroot[0] <= '0;
      qid[0]   <= idq1;
      qneg[0]  <= negq1;
    end
  end

  for (genvar k = 1; k <= NQ; k++) begin : g_qsq
    logic [19:0] cur;
    logic [19:0] trial;
    logic        take;
    assign cur   = {qrem[k-1], qv[k-1][31:30]};
    assign trial = {2'b00, qroot[k-1], 2'b01};
    assign take  = (cur >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        qvld[k] <= 1'b0;
      end else if (en) begin
        qvld[k] <= qvld[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        qv[k]    <= {qv[k-1][29:0], 2'b00};
        qrem[k]  <= take ? 18'(cur - trial) : cur[17:0];
        qroot[k] <= {qroot[k-1][14:0], take};
        qid[k]   <= qid[k-1];
        qneg[k]  <= qneg[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (en) begin
      res.valid <= qvld[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res.d_current_ref <= qid[NQ];
      res.q_current_ref <= qneg[NQ] ? -$signed({1'b0, qroot[NQ]})
                                    : $signed({1'b0, qroot[NQ]});
    end
  end

endmodule

>>> sv/mtpa_current_reference_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_current_reference_chk
// Port-level checks of the MTPA current reference, bound to the top level.
// ----------------------------------------------------------------------------
module mtpa_current_reference_chk (
  input logic        clk,
  input logic        rst,
  input logic        cmd_ready,
  input logic        res_valid,
  input logic        res_ready,
  input logic [16:0] res_d,
  input logic [16:0] res_q
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    cmd_ready == (!res_valid || res_ready))
    else $error("command ready does not follow output slot");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_d) && $stable(res_q))
    else $error("stalled transaction changed");

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_d != 17'h10000 && res_q != 17'h10000)
    else $error("reference out of range");

endmodule

bind mtpa_current_reference_top mtpa_current_reference_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .cmd_ready (cmd.ready),
  .res_valid (res.valid),
  .res_ready (res.ready),
  .res_d     (res.d_current_ref),
  .res_q     (res.q_current_ref)
);

>>> dv/mtpa_current_reference_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_current_reference_checker
// Watches the command and result channels and the register write port, keeps
// its own register copy, predicts the d/q references of every accepted
// command and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module mtpa_current_reference_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [19:0] cfg_data,
  mtpa_cmd_if.sink    cmd,
  mtpa_res_if.sink    res,
  output int          errors,
  output int          pending
);

  typedef struct packed {
    logic [16:0] d;
    logic [16:0] q;
  } dq_t;

  logic [15:0] imax;
  logic [19:0] flux, ld, lq;
  dq_t ref_q[$];

  function automatic logic [37:0] root76(logic [75:0] v);
    logic [37:0] r, t;
    r = '0;
    for (int b = 37; b >= 0; b--) begin
      t = r | (38'd1 << b);
      if ({38'd0, t} * {38'd0, t} <= v) r = t;
    end
    return r;
  endfunction

  function automatic dq_t mtpa_point(logic signed [15:0] c);
    longint icmd, amag, dl, id, iq, dmag, nmag, qt;
    logic [75:0] x, y, rad;
    logic [37:0] rt;
    logic neg;
    dq_t o;
    icmd = (longint'(c) * longint'(imax)) / 32768;
    amag = icmd < 0 ? -icmd : icmd;
    dl = longint'(lq) - longint'(ld);
    id = 0;
    if (amag != 0 && dl != 0) begin
      dmag = dl < 0 ? -dl : dl;
      x = 76'(flux) << 12;
      y = 76'(dmag) * 76'(amag);
      rad = x * x + 8 * y * y;
      rt = root76(rad);
      if (76'(rt) >= x) begin
        nmag = longint'(rt) - longint'(x);
        neg = 1;
      end else begin
        nmag = longint'(x) - longint'(rt);
        neg = 0;
      end
      if (dl < 0) neg = !neg;
      qt = nmag / (4 * dmag);
      if (qt > amag) qt = amag;
      id = neg ? -qt : qt;
    end
    if (amag == 0) iq = 0;
    else begin
      iq = longint'(root76(76'(amag * amag - id * id)));
      if (icmd < 0) iq = -iq;
    end
    o.d = id[16:0];
    o.q = iq[16:0];
    return o;
  endfunction

  assign pending = ref_q.size();

  always @(posedge clk) begin
    dq_t e;
    if (rst) begin
      imax <= '0; flux <= '0; ld <= '0; lq <= '0;
      ref_q.delete();
      errors <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          mtpa_pkg::CFG_CURRENT_MAX:  imax <= cfg_data[15:0];
          mtpa_pkg::CFG_FLUX_LINKAGE: flux <= cfg_data;
          mtpa_pkg::CFG_D_INDUCTANCE: ld <= cfg_data;
          mtpa_pkg::CFG_Q_INDUCTANCE: lq <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.valid && cmd.ready) ref_q.push_back(mtpa_point(cmd.current_ref));
      if (res.valid && res.ready) begin
        if (ref_q.size() == 0) begin
          $display("%0t: unexpected result d=%0d q=%0d", $time,
                   res.d_current_ref, res.q_current_ref);
          errors <= errors + 1;
        end else begin
          e = ref_q.pop_front();
          if (e.d !== res.d_current_ref || e.q !== res.q_current_ref) begin
            $display("%0t: mismatch expected d=%0d q=%0d actual d=%0d q=%0d", $time,
                     $signed(e.d), $signed(e.q), res.d_current_ref, res.q_current_ref);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> dv/mtpa_current_reference_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtpa_current_reference_top_tb
// Drives commands through several register settings with random idling on
// both channels and a long result stall; the checker scores every result.
// ----------------------------------------------------------------------------
module mtpa_current_reference_top_tb;

  localparam int LATENCY = 80;
  localparam int WATCHDOG = 5000;

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [1:0] cfg_index = '0;
  logic [19:0] cfg_data = '0;
  int errors, pending, quiet;
  logic hold = 0;

  mtpa_cmd_if cmd();
  mtpa_res_if res();

  mtpa_current_reference_top dut (.clk, .rst, .cfg_we, .cfg_index, .cfg_data,
                                  .cmd(cmd.sink), .res(res.source));
  mtpa_current_reference_checker chk (.clk, .rst, .cfg_we, .cfg_index, .cfg_data,
                                      .cmd(cmd.sink), .res(res.sink), .errors, .pending);

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  initial begin
    cmd.valid = 0;
    cmd.current_ref = '0;
    res.ready = 0;
  end

  always @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ready) || (res.valid && res.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= WATCHDOG) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int w;
    forever begin
      @(negedge clk);
      if (hold) res.ready <= 0;
      else begin
        w = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w == 0) res.ready <= 1;
        else begin
          res.ready <= 0;
          repeat (w) @(negedge clk);
          res.ready <= 1;
        end
        @(posedge clk);
        while (!res.valid) @(posedge clk);
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [19:0] val);
    @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
  endtask

  task automatic send_cmd(logic signed [15:0] c, bit gaps);
    int w;
    w = gaps ? $urandom_range(0, 6) : 0;
    if (w > 0) begin
      @(negedge clk);
      cmd.valid <= 0;
      repeat (w - 1) @(negedge clk);
    end
    @(negedge clk);
    cmd.valid <= 1;
    cmd.current_ref <= c;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    cmd.valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic set_motor(logic [15:0] im, logic [19:0] fl, logic [19:0] d,
                           logic [19:0] q);
    write_reg(mtpa_pkg::CFG_CURRENT_MAX, {4'd0, im});
    write_reg(mtpa_pkg::CFG_FLUX_LINKAGE, fl);
    write_reg(mtpa_pkg::CFG_D_INDUCTANCE, d);
    write_reg(mtpa_pkg::CFG_Q_INDUCTANCE, q);
  endtask

  task automatic random_motor();
    logic [19:0] d, q;
    d = 20'($urandom);
    q = 20'($urandom);
    case ($urandom_range(0, 4))
      0: q = d;
      1: q = 20'(d + $urandom_range(1, 4000));
      2: q = 20'(d - $urandom_range(1, 4000));
      default: ;
    endcase
    set_motor(16'($urandom), $urandom_range(0, 3) == 0 ? 20'hFFFFF : 20'($urandom),
              d, q);
  endtask

  initial begin
    logic signed [15:0] edge_cmds[10] = '{16'sh7FFF, -16'sh8000, 16'sd0, 16'sd1, -16'sd1,
                                          16'sh4000, -16'sh4000, 16'sd100, -16'sd100,
                                          16'sh5555};
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // zero full scale / zero delta defaults first
    foreach (edge_cmds[i]) send_cmd(edge_cmds[i], 0);
    drain();
    set_motor(16'hFFFF, 20'h40000, 20'd20000, 20'd60000);
    foreach (edge_cmds[i]) send_cmd(edge_cmds[i], 1);
    drain();
    set_motor(16'hFFFF, 20'd0, 20'hFFFFF, 20'd0);
    foreach (edge_cmds[i]) send_cmd(edge_cmds[i], 1);
    drain();
    set_motor(16'd5000, 20'hFFFFF, 20'd0, 20'hFFFFF);
    foreach (edge_cmds[i]) send_cmd(edge_cmds[i], 0);
    drain();
    for (int ph = 0; ph < 13; ph++) begin
      random_motor();
      if (ph == 4) begin
        fork
          begin
            hold = 1;
            repeat (300) @(posedge clk);
            hold = 0;
          end
        join_none
      end
      for (int n = 0; n < 150; n++) send_cmd(16'($urandom), ph % 3 != 1);
      drain();
    end
    if (errors == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end
endmodule

>>> mtpa_current_reference_top.f
sv/mtpa_pkg.sv
sv/mtpa_if.sv
sv/mtpa_dsolve.sv
sv/mtpa_current_reference_top.sv
sv/mtpa_current_reference_chk.sv
dv/mtpa_current_reference_checker.sv
dv/mtpa_current_reference_top_tb.sv
